@@ rtl/core/hmfc_pkg.sv @@
// shared types and constants of the heat map false colour block
package hmfc_pkg;

    // quotient bits of one gradient ramp step (colour components are 8 bits)
    localparam int RAMP_BITS = 8;
    localparam logic [7:0] FULL = 8'hFF;
    localparam logic [7:0] NONE = 8'h00;

    // gradient segments, taken from the top two level bits
    localparam logic [1:0] SEG_BLUE_CYAN   = 2'd0;
    localparam logic [1:0] SEG_CYAN_GREEN  = 2'd1;
    localparam logic [1:0] SEG_GREEN_YELLOW = 2'd2;
    localparam logic [1:0] SEG_YELLOW_RED  = 2'd3;

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_SETUP   = 6'b000010,
        ST_LEVEL   = 6'b000100,
        ST_RAMP_GO = 6'b001000,
        ST_RAMP    = 6'b010000,
        ST_DONE    = 6'b100000
    } state_t;

    typedef struct packed {
        logic start;
        logic ramp;   // 1: ramp division, RAMP_BITS steps; 0: level division
    } div_ctrl_t;

endpackage

@@ rtl/core/heat_map_false_colour.sv @@
// top level: two-pass min/max normalized false colour mapping
//
//  beat     direction  handshake                  payload
//  sample   in         sample_valid/sample_stall  kind, sample, frame_start
//  pixel    out        pixel_valid/pixel_stall    red, green, blue, level
//
// a measure beat does not stall the input and the next beat can follow at once
// a colour beat stalls the input through setup, the level division for the level bits,
// the load of the ramp division and the division for the eight ramp bits, and the
// load of the pixel; a flat or saturated sample skips the level division
// the pixel is valid when the input stall drops, and the next beat can be taken in that same cycle
// reset restores the tracker to the empty state (min above max)
// the result sits in an output register; a stalled pixel beat only holds the
// next colour beat at its final step
module heat_map_false_colour #(
    parameter int SAMPLE_WIDTH  = 32,
    parameter int COLOUR_LEVELS = 1024
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 sample_valid,
    output logic                                 sample_stall,
    input  logic                                 kind,
    input  logic signed [SAMPLE_WIDTH-1:0]       sample,
    input  logic                                 frame_start,
    output logic                                 pixel_valid,
    input  logic                                 pixel_stall,
    output logic [7:0]                           red,
    output logic [7:0]                           green,
    output logic [7:0]                           blue,
    output logic [$clog2(COLOUR_LEVELS)-1:0]     level
);

    localparam int LB = $clog2(COLOUR_LEVELS);
    localparam int SW = SAMPLE_WIDTH;
    localparam int DW = (SW > LB) ? SW : LB;
    localparam int TW = LB - 2;

    hmfc_pkg::state_t    state_reg;
    hmfc_pkg::state_t    state_next;
    hmfc_pkg::div_ctrl_t div_ctrl;

    logic [SW-1:0] v_reg;
    logic [SW-1:0] v_next;
    logic [LB-1:0] k_reg;
    logic [LB-1:0] k_next;
    logic [7:0]    ramp_reg;
    logic [7:0]    ramp_next;
    logic [7:0]    red_reg;
    logic [7:0]    red_next;
    logic [7:0]    green_reg;
    logic [7:0]    green_next;
    logic [7:0]    blue_reg;
    logic [7:0]    blue_next;
    logic [LB-1:0] level_reg;
    logic [LB-1:0] level_next;
    logic          pixel_valid_reg;
    logic          pixel_valid_next;

    logic          accept;
    logic [SW-1:0] v_in;
    logic [SW-1:0] min_val;
    logic [SW-1:0] max_val;
    logic [SW-1:0] diff;
    logic [SW-1:0] span;
    logic          flat;
    logic          top;
    logic [DW-1:0] rem_init;
    logic [DW-1:0] divisor;
    logic [LB-1:0] shift_in;
    logic          div_done;
    logic [LB-1:0] quotient;
    logic [TW-1:0] dividend_hi;
    logic [7:0]    dividend_lo;
    logic [7:0]    grad_red;
    logic [7:0]    grad_green;
    logic [7:0]    grad_blue;
    logic          out_free;

    assign sample_stall = (state_reg != hmfc_pkg::ST_IDLE);
    assign accept       = sample_valid && !sample_stall;
    // offset binary: unsigned order equals signed order
    assign v_in         = {~sample[SW-1], sample[SW-2:0]};

    hmfc_range #(
        .SAMPLE_WIDTH(SW)
    ) u_range (
        .clk     (clk),
        .rst_n   (rst_n),
        .update  (accept && !kind),
        .restart (frame_start),
        .value   (v_in),
        .min_val (min_val),
        .max_val (max_val)
    );

    assign diff = v_reg - min_val;
    assign span = max_val - min_val;
    assign flat = (max_val <= min_val) || (v_reg <= min_val);
    assign top  = (v_reg >= max_val);

    always_comb
    begin
        div_ctrl.start = 1'b0;
        div_ctrl.ramp  = 1'b0;
        rem_init       = DW'(diff);
        divisor        = DW'(span);
        shift_in       = '0;
        if (state_reg == hmfc_pkg::ST_SETUP)
        begin
            div_ctrl.start = !flat && !top;
        end
        else if (state_reg == hmfc_pkg::ST_RAMP_GO)
        begin
            div_ctrl.start = 1'b1;
            div_ctrl.ramp  = 1'b1;
            rem_init       = DW'(dividend_hi);
            divisor        = DW'({TW{1'b1}});
            shift_in       = LB'(dividend_lo) << (LB - hmfc_pkg::RAMP_BITS);
        end
    end

    hmfc_div #(
        .DIV_WIDTH (DW),
        .LEVEL_BITS(LB)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .rem_init (rem_init),
        .divisor  (divisor),
        .shift_in (shift_in),
        .done     (div_done),
        .quotient (quotient)
    );

    hmfc_gradient #(
        .LEVEL_BITS(LB)
    ) u_gradient (
        .level       (k_reg),
        .ramp        (ramp_reg),
        .dividend_hi (dividend_hi),
        .dividend_lo (dividend_lo),
        .red         (grad_red),
        .green       (grad_green),
        .blue        (grad_blue)
    );

    assign out_free = !pixel_valid_reg || !pixel_stall;

    always_comb
    begin
        state_next       = state_reg;
        v_next           = v_reg;
        k_next           = k_reg;
        ramp_next        = ramp_reg;
        red_next         = red_reg;
        green_next       = green_reg;
        blue_next        = blue_reg;
        level_next       = level_reg;
        pixel_valid_next = pixel_valid_reg && pixel_stall;
        case (state_reg)
            hmfc_pkg::ST_IDLE:
            begin
                if (accept && kind)
                begin
                    v_next     = v_in;
                    state_next = hmfc_pkg::ST_SETUP;
                end
            end
            hmfc_pkg::ST_SETUP:
            begin
                if (flat)
                begin
                    k_next     = '0;
                    state_next = hmfc_pkg::ST_RAMP_GO;
                end
                else if (top)
                begin
                    k_next     = '1;
                    state_next = hmfc_pkg::ST_RAMP_GO;
                end
                else
                begin
                    state_next = hmfc_pkg::ST_LEVEL;
                end
            end
            hmfc_pkg::ST_LEVEL:
            begin
                if (div_done)
                begin
                    k_next     = quotient;
                    state_next = hmfc_pkg::ST_RAMP_GO;
                end
            end
            hmfc_pkg::ST_RAMP_GO:
            begin
                state_next = hmfc_pkg::ST_RAMP;
            end
            hmfc_pkg::ST_RAMP:
            begin
                if (div_done)
                begin
                    ramp_next  = quotient[7:0];
                    state_next = hmfc_pkg::ST_DONE;
                end
            end
            hmfc_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    red_next         = grad_red;
                    green_next       = grad_green;
                    blue_next        = grad_blue;
                    level_next       = k_reg;
                    pixel_valid_next = 1'b1;
                    state_next       = hmfc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hmfc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= hmfc_pkg::ST_IDLE;
            pixel_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            pixel_valid_reg <= pixel_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg     <= v_next;
        k_reg     <= k_next;
        ramp_reg  <= ramp_next;
        red_reg   <= red_next;
        green_reg <= green_next;
        blue_reg  <= blue_next;
        level_reg <= level_next;
    end

    assign pixel_valid = pixel_valid_reg;
    assign red         = red_reg;
    assign green       = green_reg;
    assign blue        = blue_reg;
    assign level       = level_reg;

endmodule

@@ rtl/core/hmfc_range.sv @@
// running minimum and maximum of the measure pass, offset-binary form
module hmfc_range #(
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    update,
    input  logic                    restart,
    input  logic [SAMPLE_WIDTH-1:0] value,
    output logic [SAMPLE_WIDTH-1:0] min_val,
    output logic [SAMPLE_WIDTH-1:0] max_val
);

    logic [SAMPLE_WIDTH-1:0] min_reg;
    logic [SAMPLE_WIDTH-1:0] min_next;
    logic [SAMPLE_WIDTH-1:0] max_reg;
    logic [SAMPLE_WIDTH-1:0] max_next;

    always_comb
    begin
        min_next = min_reg;
        max_next = max_reg;
        if (update)
        begin
            if (restart)
            begin
                min_next = value;
                max_next = value;
            end
            else
            begin
                if (value < min_reg)
                begin
                    min_next = value;
                end
                if (value > max_reg)
                begin
                    max_next = value;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= '1;
            max_reg <= '0;
        end
        else
        begin
            min_reg <= min_next;
            max_reg <= max_next;
        end
    end

    assign min_val = min_reg;
    assign max_val = max_reg;

endmodule

@@ rtl/core/hmfc_div.sv @@
// shared bit-serial restoring divider, one quotient bit per cycle
module hmfc_div #(
    parameter int DIV_WIDTH  = 32,
    parameter int LEVEL_BITS = 10
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  hmfc_pkg::div_ctrl_t   ctrl,
    input  logic [DIV_WIDTH-1:0]  rem_init,
    input  logic [DIV_WIDTH-1:0]  divisor,
    input  logic [LEVEL_BITS-1:0] shift_in,
    output logic                  done,
    output logic [LEVEL_BITS-1:0] quotient
);

    localparam int CW = $clog2(LEVEL_BITS + 1);

    logic [DIV_WIDTH-1:0]  rem_reg;
    logic [DIV_WIDTH-1:0]  rem_next;
    logic [DIV_WIDTH-1:0]  dvs_reg;
    logic [DIV_WIDTH-1:0]  dvs_next;
    logic [LEVEL_BITS-1:0] bits_reg;
    logic [LEVEL_BITS-1:0] bits_next;
    logic [LEVEL_BITS-1:0] q_reg;
    logic [LEVEL_BITS-1:0] q_next;
    logic [CW-1:0]         cnt_reg;
    logic [CW-1:0]         cnt_next;
    logic                  busy_reg;
    logic                  busy_next;
    logic                  done_reg;
    logic                  done_next;

    logic [DIV_WIDTH:0]    trial;
    logic [DIV_WIDTH:0]    trial_sub;
    logic                  fits;

    // remainder stays below the divisor, so doubling fits one extra bit
    assign trial     = {rem_reg, bits_reg[LEVEL_BITS-1]};
    assign trial_sub = trial - {1'b0, dvs_reg};
    assign fits      = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        bits_next = bits_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctrl.start)
        begin
            rem_next  = rem_init;
            dvs_next  = divisor;
            bits_next = shift_in;
            q_next    = '0;
            cnt_next  = ctrl.ramp ? CW'(hmfc_pkg::RAMP_BITS) : CW'(LEVEL_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? trial_sub[DIV_WIDTH-1:0] : trial[DIV_WIDTH-1:0];
            q_next    = {q_reg[LEVEL_BITS-2:0], fits};
            bits_next = bits_reg << 1;
            cnt_next  = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        bits_reg <= bits_next;
        q_reg    <= q_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

@@ rtl/core/hmfc_gradient.sv @@
// four-segment gradient: ramp dividend from a level, colour from the ramp value
module hmfc_gradient #(
    parameter int LEVEL_BITS = 10
) (
    input  logic [LEVEL_BITS-1:0] level,
    input  logic [7:0]            ramp,
    output logic [LEVEL_BITS-3:0] dividend_hi,
    output logic [7:0]            dividend_lo,
    output logic [7:0]            red,
    output logic [7:0]            green,
    output logic [7:0]            blue
);

    localparam int TW = LEVEL_BITS - 2;

    logic [1:0]    seg;
    logic [TW-1:0] pos;
    logic [TW-1:0] arg;
    logic [TW+7:0] prod;

    assign seg = level[LEVEL_BITS-1:LEVEL_BITS-2];
    assign pos = level[TW-1:0];
    // falling segments count down from the segment end
    assign arg = seg[0] ? ~pos : pos;
    // arg * 255 as shift and subtract
    assign prod = {arg, 8'h00} - (TW + 8)'(arg);
    assign dividend_hi = prod[TW+7:8];
    assign dividend_lo = prod[7:0];

    always_comb
    begin
        case (seg)
            hmfc_pkg::SEG_BLUE_CYAN:
            begin
                red   = hmfc_pkg::NONE;
                green = ramp;
                blue  = hmfc_pkg::FULL;
            end
            hmfc_pkg::SEG_CYAN_GREEN:
            begin
                red   = hmfc_pkg::NONE;
                green = hmfc_pkg::FULL;
                blue  = ramp;
            end
            hmfc_pkg::SEG_GREEN_YELLOW:
            begin
                red   = ramp;
                green = hmfc_pkg::FULL;
                blue  = hmfc_pkg::NONE;
            end
            default:
            begin
                red   = hmfc_pkg::FULL;
                green = ramp;
                blue  = hmfc_pkg::NONE;
            end
        endcase
    end

endmodule
